[design/tlot_pkg.sv]
// ----------------------------------------------------------------------------
// tlot_pkg
// Shared types and codes for the two-lane transfer order tracker.
// ----------------------------------------------------------------------------
package tlot_pkg;

  localparam int TAG_W      = 4;
  localparam int TAG_SPACE  = 1 << TAG_W;
  localparam int MODE_W     = 3;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int LANE_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQUEUE  = 3'd0,
    MODE_CLAIM    = 3'd1,
    MODE_PUBLISH  = 3'd2,
    MODE_QUERY    = 3'd3,
    MODE_COMPLETE = 3'd4
  } mode_t;

  localparam logic [KIND_W-1:0] KIND_PREFETCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  localparam logic [LANE_W-1:0] LANE_FETCH = 2'd0;
  localparam logic [LANE_W-1:0] LANE_EVICT = 2'd1;
  localparam logic [LANE_W-1:0] LANE_NONE  = 2'd2;

  typedef logic [1:0] tag_st_t;
  localparam tag_st_t ST_NONE     = 2'd0;
  localparam tag_st_t ST_PENDING  = 2'd1;
  localparam tag_st_t ST_INFLIGHT = 2'd2;

  // queue index = {lane, role}
  localparam logic ROLE_PENDING  = 1'b0;
  localparam logic ROLE_INFLIGHT = 1'b1;
  localparam int   QUEUE_COUNT   = 4;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

[design/tlot_fifo.sv]
// ----------------------------------------------------------------------------
// tlot_fifo
// Tag FIFO with a registered front entry. The memory read port runs one
// entry ahead of the head so a pop can refill the front in the same cycle.
// ----------------------------------------------------------------------------
module tlot_fifo
  import tlot_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fifo_ctl_t        ctl,
  input  logic [TAG_W-1:0] din,
  output logic [TAG_W-1:0] front,
  output fifo_stat_t       stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [TAG_W-1:0] mem [DEPTH];
  logic [PW-1:0]    head_r, head_nxt, head_inc, raddr;
  logic [CW-1:0]    count_r;
  logic [TAG_W-1:0] front_r, second_r;
  logic [SW-1:0]    tail_sum;
  logic [PW-1:0]    tail;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail = tail_sum[PW-1:0];
  end

  assign head_inc = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_nxt = ctl.pop ? head_inc : head_r;
  assign raddr    = (head_nxt == PW'(DEPTH - 1)) ? '0 : head_nxt + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= din;
    end
    // second entry behind the head, with write bypass
    if (ctl.push && tail == raddr) begin
      second_r <= din;
    end else begin
      second_r <= mem[raddr];
    end
    if (ctl.push && count_r == '0) begin
      front_r <= din;
    end else if (ctl.pop) begin
      front_r <= second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r <= head_nxt;
      if (ctl.push) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign front      = front_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

endmodule

[design/two_lane_transfer_order_tracker_unit.sv]
// ----------------------------------------------------------------------------
// two_lane_transfer_order_tracker_unit
// Fetch and evict lanes, each with a pending and an in-flight tag FIFO, plus
// a per-tag state table. One result per transfer.
// ----------------------------------------------------------------------------
// Path: input register, then result register; a result stays held in the result
//   register while the output is stalled.
// Throughput: one transfer per cycle while the output is not stalled; each op
//   touches at most one FIFO end and one tag state entry.
// Reset clears all FIFOs and tag states.
// ----------------------------------------------------------------------------
module two_lane_transfer_order_tracker_unit
  import tlot_pkg::*;
#(
  parameter int TAG_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // mode[2:0], action_tag[6:3], action_kind[8:7]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], lane_used[3:2]
);

  localparam int TAG_LIM = (TAG_COUNT < TAG_SPACE) ? TAG_COUNT : TAG_SPACE;
  localparam int TIW     = $clog2(TAG_LIM);

  // input register
  logic              s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic [KIND_W-1:0] s1_kind_r;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LANE_W-1:0]   out_lane_r;

  tag_st_t tag_state_r [TAG_LIM];

  logic advance, commit;
  logic is_release, tag_ok, lane_bit;
  logic [1:0] pq, fq;
  logic [TIW-1:0] tidx;
  tag_st_t cur_st;
  logic [STATUS_W-1:0] status_nxt;
  logic [LANE_W-1:0]   lane_nxt;
  logic    st_we;
  tag_st_t st_wdata;
  logic [1:0] q_sel;

  fifo_ctl_t        q_ctl   [QUEUE_COUNT];
  fifo_stat_t       q_stat  [QUEUE_COUNT];
  logic [TAG_W-1:0] q_front [QUEUE_COUNT];

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign commit    = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tdata[MODE_W-1:0];
      s1_tag_r  <= in_tdata[MODE_W +: TAG_W];
      s1_kind_r <= in_tdata[MODE_W + TAG_W +: KIND_W];
    end
  end

  assign is_release = (s1_kind_r == KIND_RELEASE);
  assign lane_bit   = (s1_kind_r != KIND_PREFETCH);
  assign tag_ok     = (32'(s1_tag_r) < TAG_COUNT);
  assign pq         = {lane_bit, ROLE_PENDING};
  assign fq         = {lane_bit, ROLE_INFLIGHT};
  assign tidx       = s1_tag_r[TIW-1:0];
  assign cur_st     = tag_state_r[tidx];

  always_comb begin
    status_nxt = STATUS_NO;
    lane_nxt   = lane_bit ? LANE_EVICT : LANE_FETCH;
    st_we      = 1'b0;
    st_wdata   = ST_NONE;
    q_sel      = pq;
    for (int i = 0; i < QUEUE_COUNT; i++) begin
      q_ctl[i] = '0;
    end
    if (is_release) begin
      lane_nxt = LANE_NONE;
    end else if (tag_ok) begin
      case (s1_mode_r)
        MODE_ENQUEUE: begin
          q_sel = pq;
          if (q_stat[pq].full) begin
            status_nxt = STATUS_FULL;
          end else begin
            status_nxt       = STATUS_OK;
            q_ctl[pq].push   = commit;
            st_we            = commit;
            st_wdata         = ST_PENDING;
          end
        end
        MODE_CLAIM: begin
          q_sel = pq;
          if (!q_stat[pq].empty && q_front[pq] == s1_tag_r && cur_st == ST_PENDING) begin
            status_nxt     = STATUS_OK;
            q_ctl[pq].pop  = commit;
            st_we          = commit;
            st_wdata       = ST_NONE;
          end
        end
        MODE_PUBLISH: begin
          q_sel = fq;
          if (q_stat[fq].full) begin
            status_nxt = STATUS_FULL;
          end else begin
            status_nxt     = STATUS_OK;
            q_ctl[fq].push = commit;
            st_we          = commit;
            st_wdata       = ST_INFLIGHT;
          end
        end
        MODE_QUERY: begin
          q_sel = fq;
          if (!q_stat[fq].empty && q_front[fq] == s1_tag_r && cur_st == ST_INFLIGHT) begin
            status_nxt = STATUS_OK;
          end
        end
        MODE_COMPLETE: begin
          q_sel = fq;
          if (!q_stat[fq].empty && q_front[fq] == s1_tag_r && cur_st == ST_INFLIGHT) begin
            status_nxt    = STATUS_OK;
            q_ctl[fq].pop = commit;
            st_we         = commit;
            st_wdata      = ST_NONE;
          end
        end
        default: begin
          status_nxt = STATUS_NO;
        end
      endcase
    end
  end

  for (genvar q = 0; q < QUEUE_COUNT; q++) begin : g_queue
    tlot_fifo #(
      .DEPTH(TAG_COUNT)
    ) u_fifo (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (q_ctl[q]),
      .din  (s1_tag_r),
      .front(q_front[q]),
      .stat (q_stat[q])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAG_LIM; i++) begin
        tag_state_r[i] <= ST_NONE;
      end
    end else if (st_we) begin
      tag_state_r[tidx] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status_nxt;
      out_lane_r   <= lane_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - LANE_W){1'b0}}, out_lane_r, out_status_r};

  // at most one FIFO end moves per cycle
  a_one_fifo_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({q_ctl[0].push, q_ctl[0].pop, q_ctl[1].push, q_ctl[1].pop,
              q_ctl[2].push, q_ctl[2].pop, q_ctl[3].push, q_ctl[3].pop}))
    else $error("more than one FIFO operation in a cycle");

  // release transfers are refused without a lane
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    commit && is_release |=> out_tvalid && out_tdata[STATUS_W-1:0] == STATUS_NO &&
                             out_tdata[STATUS_W +: LANE_W] == LANE_NONE)
    else $error("release transfer not refused");

  // a pop of the fetch pending FIFO only occurs when it is the op's target queue and not empty
  a_target_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (q_ctl[0].push || q_ctl[0].pop) |-> q_sel == 2'd0 && !q_stat[0].empty || q_ctl[0].push)
    else $error("fetch pending FIFO touched by the wrong op");

  // store of a tag state only on a committed op
  a_state_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> commit && tag_ok && !is_release)
    else $error("tag state written without a committed transfer");

endmodule

[sim/tb_two_lane_transfer_order_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tb_two_lane_transfer_order_tracker_unit
// Self-checking bench for the two-lane transfer order tracker. A tracking
// model of both lanes (pending and in-flight tag FIFOs plus the per-tag
// state) predicts status and lane for every accepted transfer. Directed
// cases come first, then random sequences that are mostly well formed,
// under bursty input, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_two_lane_transfer_order_tracker_unit;
  import tlot_pkg::*;

  localparam int TAGS        = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 10;

  localparam logic [KIND_W-1:0] KIND_EVICT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT_ALT = 2'd3;  // not release, so evict lane
  localparam logic [MODE_W-1:0] MODE_FIRST_UNDEF = 3'd5;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [LANE_W-1:0]   lane;
  } outcome_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  two_lane_transfer_order_tracker_unit #(.TAG_COUNT(TAGS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // tracking model of the lanes
  logic [TAG_W-1:0] fifo_mem [QUEUE_COUNT][TAGS];
  int               fifo_head [QUEUE_COUNT];
  int               fifo_cnt  [QUEUE_COUNT];
  tag_st_t          tag_st    [TAGS];
  logic [TAG_W-1:0] last_claim [2];
  outcome_t         due_results [$];

  int  errors;
  int  sent_cnt;
  int  checked_cnt;
  int  ok_cnt;
  int  no_cnt;
  int  full_cnt;
  int  cycle_cnt;
  int  burst_left;
  bit  bursty;
  bit  hold_req;
  int  hold_left;
  int  rx_cycle;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               due_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_cnt, msg);
    errors++;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_op(input logic [MODE_W-1:0] m,
                                                   input logic [TAG_W-1:0]  tg,
                                                   input logic [KIND_W-1:0] k);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[2:0] = m;
    d[6:3] = tg;
    d[8:7] = k;
    return d;
  endfunction

  function automatic bit fifo_push(input int q, input logic [TAG_W-1:0] tg);
    if (fifo_cnt[q] >= TAGS) return 1'b0;
    fifo_mem[q][(fifo_head[q] + fifo_cnt[q]) % TAGS] = tg;
    fifo_cnt[q]++;
    return 1'b1;
  endfunction

  function automatic bit fifo_head_is(input int q, input logic [TAG_W-1:0] tg);
    if (fifo_cnt[q] == 0) return 1'b0;
    return fifo_mem[q][fifo_head[q]] == tg;
  endfunction

  function automatic void fifo_pop(input int q);
    fifo_head[q] = (fifo_head[q] + 1) % TAGS;
    fifo_cnt[q]--;
  endfunction

  // Applies one transfer to the model and queues the result it must give.
  task automatic track_op(input logic [IN_DATA_W-1:0] d);
    logic [MODE_W-1:0] m;
    logic [TAG_W-1:0]  tg;
    logic [KIND_W-1:0] k;
    outcome_t          r;
    int                ln;
    int                pq;
    int                fq;
    m  = d[2:0];
    tg = d[6:3];
    k  = d[8:7];
    r.status = STATUS_NO;
    if (k == KIND_RELEASE) begin
      r.lane = LANE_NONE;
    end else begin
      r.lane = (k == KIND_PREFETCH) ? LANE_FETCH : LANE_EVICT;
      ln = (k == KIND_PREFETCH) ? 0 : 1;
      pq = 2 * ln + int'(ROLE_PENDING);
      fq = 2 * ln + int'(ROLE_INFLIGHT);
      case (m)
        MODE_ENQUEUE: begin
          if (fifo_push(pq, tg)) begin
            tag_st[tg] = ST_PENDING;
            r.status = STATUS_OK;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        MODE_CLAIM: begin
          if (fifo_head_is(pq, tg) && tag_st[tg] == ST_PENDING) begin
            fifo_pop(pq);
            tag_st[tg] = ST_NONE;
            last_claim[ln] = tg;
            r.status = STATUS_OK;
          end
        end
        MODE_PUBLISH: begin
          if (fifo_push(fq, tg)) begin
            tag_st[tg] = ST_INFLIGHT;
            r.status = STATUS_OK;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        MODE_QUERY: begin
          if (fifo_head_is(fq, tg) && tag_st[tg] == ST_INFLIGHT) r.status = STATUS_OK;
        end
        MODE_COMPLETE: begin
          if (fifo_head_is(fq, tg) && tag_st[tg] == ST_INFLIGHT) begin
            fifo_pop(fq);
            tag_st[tg] = ST_NONE;
            r.status = STATUS_OK;
          end
        end
        default: r.status = STATUS_NO;
      endcase
    end
    due_results.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid is left high so the next transfer can follow back to back.
  task automatic send_op(input logic [IN_DATA_W-1:0] d);
    int gap;
    if (bursty && burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    track_op(d);
    sent_cnt++;
    @(negedge clk);
  endtask

  // Random transfer that mostly follows the lane protocol, using the model to
  // aim claims, queries and completes at current FIFO heads.
  function automatic logic [IN_DATA_W-1:0] pick_op(input int w_enq, input int w_claim,
                                                   input int w_pub, input int w_query,
                                                   input int w_done);
    logic [MODE_W-1:0] m;
    logic [TAG_W-1:0]  tg;
    logic [KIND_W-1:0] k;
    int                ln;
    int                pq;
    int                fq;
    int                roll;
    int                start;
    if ($urandom_range(99) < 8) begin
      m  = MODE_W'($urandom);
      tg = TAG_W'($urandom);
      k  = KIND_W'($urandom);
      return pack_op(m, tg, k);
    end
    ln = $urandom_range(1);
    k  = (ln == 0) ? KIND_PREFETCH : (($urandom_range(3) == 0) ? KIND_EVICT_ALT : KIND_EVICT);
    pq = 2 * ln + int'(ROLE_PENDING);
    fq = 2 * ln + int'(ROLE_INFLIGHT);
    tg = TAG_W'($urandom);
    roll = $urandom_range(w_enq + w_claim + w_pub + w_query + w_done - 1);
    if (roll < w_enq) begin
      m = MODE_ENQUEUE;
      // prefer an idle tag so stale FIFO copies stay the exception
      if ($urandom_range(9) < 7) begin
        start = $urandom_range(TAGS - 1);
        for (int i = 0; i < TAGS; i++) begin
          if (tag_st[(start + i) % TAGS] == ST_NONE) begin
            tg = TAG_W'((start + i) % TAGS);
            break;
          end
        end
      end
    end else if (roll < w_enq + w_claim) begin
      m = MODE_CLAIM;
      if (fifo_cnt[pq] > 0 && $urandom_range(9) < 8) tg = fifo_mem[pq][fifo_head[pq]];
    end else if (roll < w_enq + w_claim + w_pub) begin
      m = MODE_PUBLISH;
      if ($urandom_range(3) != 0) tg = last_claim[ln];
    end else begin
      m = (roll < w_enq + w_claim + w_pub + w_query) ? MODE_QUERY : MODE_COMPLETE;
      if (fifo_cnt[fq] > 0 && $urandom_range(9) < 8) tg = fifo_mem[fq][fifo_head[fq]];
    end
    return pack_op(m, tg, k);
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    logic [STATUS_W-1:0] got_status;
    logic [LANE_W-1:0]   got_lane;
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata[1:0];
      got_lane   = out_tdata[3:2];
      if (got_status == STATUS_OK) ok_cnt++;
      else if (got_status == STATUS_NO) no_cnt++;
      else if (got_status == STATUS_FULL) full_cnt++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing due (status %0d lane %0d)",
                                  got_status, got_lane));
      end else begin
        want = due_results.pop_front();
        checked_cnt++;
        if (got_status !== want.status)
          report_mismatch($sformatf("status got %0d, want %0d", got_status, want.status));
        if (got_lane !== want.lane)
          report_mismatch($sformatf("lane got %0d, want %0d", got_lane, want.lane));
      end
    end
  end

  // receiver: rotating stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 89) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(99) < 70);
        2: out_tready <= ($urandom_range(99) < 30);
        default: out_tready <= rx_cycle[0];
      endcase
    end
  end

  task automatic test_basic_ops;
    logic [KIND_W-1:0] undef_kind [3];
    undef_kind = '{KIND_PREFETCH, KIND_EVICT, KIND_EVICT_ALT};
    // empty FIFOs right after reset
    send_op(pack_op(MODE_CLAIM, 4'd0, KIND_PREFETCH));
    send_op(pack_op(MODE_QUERY, 4'd15, KIND_EVICT));
    // one clean pass through the fetch pending FIFO, with a non-head claim
    send_op(pack_op(MODE_ENQUEUE, 4'd0, KIND_PREFETCH));
    send_op(pack_op(MODE_CLAIM, 4'd5, KIND_PREFETCH));
    send_op(pack_op(MODE_CLAIM, 4'd0, KIND_PREFETCH));
    // in-flight pass on the evict lane, selected by the odd kind value
    send_op(pack_op(MODE_PUBLISH, 4'd15, KIND_EVICT_ALT));
    send_op(pack_op(MODE_QUERY, 4'd15, KIND_EVICT));
    send_op(pack_op(MODE_COMPLETE, 4'd15, KIND_EVICT));
    send_op(pack_op(MODE_COMPLETE, 4'd15, KIND_EVICT));
    // release is always refused
    send_op(pack_op(MODE_ENQUEUE, 4'd3, KIND_RELEASE));
    send_op(pack_op(MODE_COMPLETE, 4'd9, KIND_RELEASE));
    for (int i = 0; i < 3; i++)
      send_op(pack_op(MODE_FIRST_UNDEF + MODE_W'(i), TAG_W'(i * 7), undef_kind[i]));
    // re-queued tag: wrong state at the pending head, then a stale copy
    send_op(pack_op(MODE_ENQUEUE, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_PUBLISH, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_CLAIM, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_QUERY, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_COMPLETE, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_ENQUEUE, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_CLAIM, 4'd7, KIND_PREFETCH));
    send_op(pack_op(MODE_CLAIM, 4'd7, KIND_PREFETCH));
  endtask

  // fill the evict pending FIFO past its depth
  task automatic test_full_queue;
    for (int i = 0; i <= TAGS; i++)
      send_op(pack_op(MODE_ENQUEUE, TAG_W'(TAGS - 1 - (i % TAGS)), KIND_EVICT));
  endtask

  task automatic test_random_mix(input int n, input int w_enq, input int w_claim,
                                 input int w_pub, input int w_query, input int w_done);
    repeat (n) send_op(pick_op(w_enq, w_claim, w_pub, w_query, w_done));
  endtask

  // long output hold-off while input keeps streaming
  task automatic test_backpressure;
    bursty   = 1'b0;
    hold_req = 1'b1;
    test_random_mix(120, 3, 3, 3, 2, 3);
    bursty = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    bursty     = 1'b1;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      fifo_head[q] = 0;
      fifo_cnt[q]  = 0;
    end
    for (int t = 0; t < TAGS; t++) tag_st[t] = ST_NONE;
    last_claim = '{default: '0};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ops;
    test_full_queue;
    test_random_mix(500, 3, 3, 3, 2, 3);
    test_random_mix(200, 6, 1, 6, 1, 1);
    test_backpressure;
    test_random_mix(250, 1, 6, 2, 2, 6);
    test_random_mix(130, 3, 3, 3, 2, 3);

    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d transfers in %0d cycles, %0d results checked",
             sent_cnt, cycle_cnt, checked_cnt);
    $display("results seen: done %0d, refused %0d, full %0d", ok_cnt, no_cnt, full_cnt);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
